>>> hw/rtl/fth_pkg.sv
// Package for the face-target heading block.
// Holds the transfer structs, the CORDIC datapath widths and the arctangent table.
// No dependencies.
package fth_pkg;

  // Pose transfer: person in robot frame, robot world position and orientation.
  typedef struct packed {
    logic signed [31:0] person_x;
    logic signed [31:0] person_y;
    logic signed [31:0] robot_x;
    logic signed [31:0] robot_y;
    logic signed [15:0] robot_qx;
    logic signed [15:0] robot_qy;
    logic signed [15:0] robot_qz;
    logic signed [15:0] robot_qw;
  } pose_t;

  // Goal transfer: robot position and heading quaternion (z, w).
  typedef struct packed {
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [15:0] heading_qz;
    logic [14:0]        heading_qw;
  } goal_t;

  // Vectoring datapath width: holds quaternion terms and Q16.16 vectors with gain
  localparam int VW = 40;
  // Rotation datapath width for x, y and the residual angle
  localparam int RW = 34;

  localparam logic [31:0] TURN_HALF = 32'h8000_0000;
  // 2^30 divided by the CORDIC gain
  localparam logic signed [RW-1:0] INV_GAIN_Q30 = RW'(652032874);
  localparam logic signed [RW-1:0] ROUND_HALF = RW'(32768);
  localparam logic signed [RW-1:0] Q14_ONE = RW'(16384);

  // atan(2^-i) in binary-angle units (2^32 per turn)
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

endpackage

>>> hw/rtl/face_target_heading_quaternion.sv
// Face-target heading block, top level.
// Depends on fth_pkg, fth_vec_stage and fth_rot_stage.
//
// Usage:
//   The pose channel (pose_valid, pose, pose_stall) carries the robot's world
//   position, its orientation quaternion (Q2.14) and a person's position in the
//   robot frame (Q16.16). The goal channel (goal_valid, goal, goal_stall) returns
//   one goal per pose: the robot position and a heading quaternion (qz, qw) that
//   faces the person.
//   The pipe has 2*N+6 register stages, N being CORDIC_STAGES capped at 32:
//   input register, quaternion products, yaw terms, CORDIC set-up, N vectoring
//   iterations (yaw and person run side by side), heading sum, N rotation
//   iterations and the rounding register. Throughput is one pose per cycle
//   while goal_stall is low; every CORDIC iteration is its own stage.
//   Each stage holds its own valid bit, so empty stages fill while goal_stall
//   is high, and pose_stall rises only once the whole pipe is full.
//   A stalled goal holds its value until transferred.
//   Reset clears all valid bits; no goal is pending after reset.
module face_target_heading_quaternion import fth_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  pose_valid,
  input  pose_t pose,
  output logic  pose_stall,
  output logic  goal_valid,
  output goal_t goal,
  input  logic  goal_stall
);

  localparam int N      = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int S_IN   = 0;
  localparam int S_MUL  = 1;
  localparam int S_SUM  = 2;
  localparam int S_INIT = 3;
  localparam int S_HEAD = S_INIT + N + 1;
  localparam int S_OUT  = S_HEAD + N + 1;
  localparam int L      = S_OUT + 1;

  logic [L-1:0] v;
  logic [L-1:0] ready;

  // Stall chain: a stage loads when it is empty or the next one moves
  always_comb begin
    ready[L-1] = !v[L-1] || !goal_stall;
    for (int k = L - 2; k >= 0; k--) begin
      ready[k] = !v[k] || ready[k+1];
    end
  end

  assign pose_stall = !ready[S_IN];
  assign goal_valid = v[S_OUT];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ready[0]) begin
        v[0] <= pose_valid;
      end
      for (int k = 1; k < L; k++) begin
        if (ready[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Carry robot position and the special-case flags along the pipe
  logic signed [31:0] gx [L];
  logic signed [31:0] gy [L];
  logic               yaw_ok [L];
  logic               pzero [L];

  // Input and product stages
  pose_t              in_q;
  logic signed [31:0] p_xy, p_wz, p_xx, p_yy, p_zz, p_ww, p_xz, p_wy;
  logic signed [31:0] px1, py1;
  logic signed [35:0] a2, b2;
  logic signed [31:0] px2, py2;
  logic signed [35:0] a_c, b_c, c_c, d_c, c_abs;

  always_ff @(posedge clk) begin
    if (ready[S_IN]) begin
      in_q <= pose;
    end
    // Quaternion products
    if (ready[S_MUL]) begin
      p_xy <= 32'(in_q.robot_qx * in_q.robot_qy);
      p_wz <= 32'(in_q.robot_qw * in_q.robot_qz);
      p_xx <= 32'(in_q.robot_qx * in_q.robot_qx);
      p_yy <= 32'(in_q.robot_qy * in_q.robot_qy);
      p_zz <= 32'(in_q.robot_qz * in_q.robot_qz);
      p_ww <= 32'(in_q.robot_qw * in_q.robot_qw);
      p_xz <= 32'(in_q.robot_qx * in_q.robot_qz);
      p_wy <= 32'(in_q.robot_qw * in_q.robot_qy);
      px1  <= in_q.person_x;
      py1  <= in_q.person_y;
    end
  end

  // Yaw terms and gimbal-lock test
  always_comb begin
    a_c = 36'(p_xy) + 36'(p_wz);
    a_c = a_c <<< 1;
    d_c = 36'(p_xx) + 36'(p_yy) + 36'(p_zz) + 36'(p_ww);
    b_c = d_c - ((36'(p_yy) + 36'(p_zz)) <<< 1);
    c_c = (36'(p_xz) - 36'(p_wy)) <<< 1;
    c_abs = (c_c < 0) ? -c_c : c_c;
  end

  always_ff @(posedge clk) begin
    if (ready[S_SUM]) begin
      a2  <= a_c;
      b2  <= b_c;
      px2 <= px1;
      py2 <= py1;
    end
  end

  generate
    for (genvar k = 0; k < L; k++) begin : g_side
      if (k == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (ready[k]) begin
            gx[k]     <= pose.robot_x;
            gy[k]     <= pose.robot_y;
            yaw_ok[k] <= 1'b0;
            pzero[k]  <= 1'b0;
          end
        end
      end else if (k == S_SUM) begin : g_flags
        always_ff @(posedge clk) begin
          if (ready[k]) begin
            gx[k]     <= gx[k-1];
            gy[k]     <= gy[k-1];
            yaw_ok[k] <= (d_c != 0) && (c_abs < d_c);
            pzero[k]  <= (px1 == 0) && (py1 == 0);
          end
        end
      end else begin : g_carry
        always_ff @(posedge clk) begin
          if (ready[k]) begin
            gx[k]     <= gx[k-1];
            gy[k]     <= gy[k-1];
            yaw_ok[k] <= yaw_ok[k-1];
            pzero[k]  <= pzero[k-1];
          end
        end
      end
    end
  endgenerate

  // Vectoring pipelines: yaw from the quaternion, bearing of the person
  logic signed [VW-1:0] yaw_x [N+1];
  logic signed [VW-1:0] yaw_y [N+1];
  logic [31:0]          yaw_z [N+1];
  logic signed [VW-1:0] per_x [N+1];
  logic signed [VW-1:0] per_y [N+1];
  logic [31:0]          per_z [N+1];

  logic signed [VW-1:0] yb, ya, pxe, pye;
  assign yb  = VW'(b2);
  assign ya  = VW'(a2);
  assign pxe = VW'(px2);
  assign pye = VW'(py2);

  // Fold vectors with negative x into the right half plane
  always_ff @(posedge clk) begin
    if (ready[S_INIT]) begin
      if (yb < 0) begin
        yaw_x[0] <= -yb;
        yaw_y[0] <= -ya;
        yaw_z[0] <= TURN_HALF;
      end else begin
        yaw_x[0] <= yb;
        yaw_y[0] <= ya;
        yaw_z[0] <= '0;
      end
      if (pxe < 0) begin
        per_x[0] <= -pxe;
        per_y[0] <= -pye;
        per_z[0] <= TURN_HALF;
      end else begin
        per_x[0] <= pxe;
        per_y[0] <= pye;
        per_z[0] <= '0;
      end
    end
  end

  generate
    for (genvar j = 0; j < N; j++) begin : g_vec
      fth_vec_stage #(.SHIFT(j)) u_yaw (
        .clk  (clk),
        .load (ready[S_INIT+1+j]),
        .x_in (yaw_x[j]),
        .y_in (yaw_y[j]),
        .z_in (yaw_z[j]),
        .x    (yaw_x[j+1]),
        .y    (yaw_y[j+1]),
        .z    (yaw_z[j+1])
      );
      fth_vec_stage #(.SHIFT(j)) u_per (
        .clk  (clk),
        .load (ready[S_INIT+1+j]),
        .x_in (per_x[j]),
        .y_in (per_y[j]),
        .z_in (per_z[j]),
        .x    (per_x[j+1]),
        .y    (per_y[j+1]),
        .z    (per_z[j+1])
      );
    end
  endgenerate

  // Heading sum and half angle
  logic [31:0]          head;
  logic [31:0]          half;
  logic signed [RW-1:0] rot_x [N+1];
  logic signed [RW-1:0] rot_y [N+1];
  logic signed [RW-1:0] rot_z [N+1];

  always_comb begin
    if (pzero[S_HEAD-1]) begin
      head = '0;
    end else if (yaw_ok[S_HEAD-1]) begin
      head = per_z[N] + yaw_z[N];
    end else begin
      head = per_z[N];
    end
    half = {head[31], head[31:1]};
  end

  always_ff @(posedge clk) begin
    if (ready[S_HEAD]) begin
      rot_x[0] <= INV_GAIN_Q30;
      rot_y[0] <= '0;
      rot_z[0] <= RW'($signed(half));
    end
  end

  generate
    for (genvar j = 0; j < N; j++) begin : g_rot
      fth_rot_stage #(.SHIFT(j)) u_rot (
        .clk  (clk),
        .load (ready[S_HEAD+1+j]),
        .x_in (rot_x[j]),
        .y_in (rot_y[j]),
        .z_in (rot_z[j]),
        .x    (rot_x[j+1]),
        .y    (rot_y[j+1]),
        .z    (rot_z[j+1])
      );
    end
  endgenerate

  // Round to Q2.14 and clamp
  logic signed [RW-1:0] cos_r, sin_r;
  logic [14:0]          qw_c;
  logic signed [15:0]   qz_c;

  always_comb begin
    cos_r = (rot_x[N] + ROUND_HALF) >>> 16;
    sin_r = (rot_y[N] + ROUND_HALF) >>> 16;
    if (cos_r < 0) begin
      qw_c = '0;
    end else if (cos_r > Q14_ONE) begin
      qw_c = 15'(Q14_ONE);
    end else begin
      qw_c = cos_r[14:0];
    end
    if (sin_r < -Q14_ONE) begin
      qz_c = -16'(Q14_ONE);
    end else if (sin_r > Q14_ONE) begin
      qz_c = 16'(Q14_ONE);
    end else begin
      qz_c = sin_r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ready[S_OUT]) begin
      goal.goal_x     <= gx[S_OUT-1];
      goal.goal_y     <= gy[S_OUT-1];
      goal.heading_qz <= qz_c;
      goal.heading_qw <= qw_c;
    end
  end

endmodule

>>> hw/rtl/fth_vec_stage.sv
// One registered vectoring CORDIC iteration (atan2).
// Depends on fth_pkg for widths and the arctangent table.
module fth_vec_stage import fth_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic                 clk,
  input  logic                 load,
  input  logic signed [VW-1:0] x_in,
  input  logic signed [VW-1:0] y_in,
  input  logic [31:0]          z_in,
  output logic signed [VW-1:0] x,
  output logic signed [VW-1:0] y,
  output logic [31:0]          z
);

  logic signed [VW-1:0] x_next;
  logic signed [VW-1:0] y_next;
  logic [31:0]          z_next;

  // Drive y toward zero, accumulate the angle turned
  always_comb begin
    if (y_in > 0) begin
      x_next = x_in + (y_in >>> SHIFT);
      y_next = y_in - (x_in >>> SHIFT);
      z_next = z_in + ATAN_TAB[SHIFT];
    end else begin
      x_next = x_in - (y_in >>> SHIFT);
      y_next = y_in + (x_in >>> SHIFT);
      z_next = z_in - ATAN_TAB[SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
  end

endmodule

>>> hw/rtl/fth_rot_stage.sv
// One registered rotation CORDIC iteration (sine and cosine).
// Depends on fth_pkg for widths and the arctangent table.
module fth_rot_stage import fth_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic                 clk,
  input  logic                 load,
  input  logic signed [RW-1:0] x_in,
  input  logic signed [RW-1:0] y_in,
  input  logic signed [RW-1:0] z_in,
  output logic signed [RW-1:0] x,
  output logic signed [RW-1:0] y,
  output logic signed [RW-1:0] z
);

  logic signed [RW-1:0] x_next;
  logic signed [RW-1:0] y_next;
  logic signed [RW-1:0] z_next;

  // Turn the vector toward the residual angle
  always_comb begin
    if (z_in >= 0) begin
      x_next = x_in - (y_in >>> SHIFT);
      y_next = y_in + (x_in >>> SHIFT);
      z_next = z_in - $signed({{(RW-32){1'b0}}, ATAN_TAB[SHIFT]});
    end else begin
      x_next = x_in + (y_in >>> SHIFT);
      y_next = y_in - (x_in >>> SHIFT);
      z_next = z_in + $signed({{(RW-32){1'b0}}, ATAN_TAB[SHIFT]});
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
  end

endmodule
